FILE: src/evrs_pkg.sv
`default_nettype none
package evrs_pkg;

    localparam int MAX_ROWS     = 4096;
    localparam int MAX_COLS     = 16;
    localparam int MAX_PER_SIDE = 64;
    localparam int VALUE_W      = 32;
    localparam int ROW_W        = 12;
    localparam int COL_W        = 4;
    localparam int CNT_W        = 13;
    localparam int PCOL_W       = 5;
    localparam int PS_W         = 7;
    localparam int SLOT_W       = 6;
    localparam int SLOT_AW      = COL_W + SLOT_W;
    localparam int MAP_BITS     = 64;
    localparam int MAP_BIT_W    = 6;
    localparam int MAP_AW       = ROW_W - MAP_BIT_W;
    localparam int MAP_DEPTH    = MAX_ROWS / MAP_BITS;
    localparam int DIV_STEPS    = CNT_W;
    localparam int DIV_W        = PCOL_W + 1;

    localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] REG_TARGET_COUNT = 2'd2;
    localparam logic [1:0] REG_SKIP_FIRST   = 2'd3;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_FETCH   = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [ROW_W-1:0]          row;
    } entry_t;

    // Lowest set bit of a map word.
    function automatic logic [MAP_BIT_W-1:0] lowest_set(input logic [MAP_BITS-1:0] w);
        logic [MAP_BIT_W-1:0] idx;
        idx = '0;
        for (int i = MAP_BITS - 1; i >= 0; i--) begin
            if (w[i]) idx = MAP_BIT_W'(i);
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

FILE: src/evrs_div.sv
`default_nettype none
module evrs_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [evrs_pkg::CNT_W-1:0] dividend,
    input  wire logic [evrs_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic [evrs_pkg::CNT_W-1:0]     quotient
);
    import evrs_pkg::*;

    logic              busy_reg;
    logic [3:0]        step_reg;
    logic [CNT_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W:0]    trial;

    // One quotient bit per cycle, restoring.
    assign trial = {rem_reg, dvd_reg[CNT_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            step_reg <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                quotient <= '0;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[CNT_W-2:0], 1'b0};
                if (trial >= {1'b0, dsr_reg}) begin
                    rem_reg  <= DIV_W'(trial - {1'b0, dsr_reg});
                    quotient <= {quotient[CNT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= trial[DIV_W-1:0];
                    quotient <= {quotient[CNT_W-2:0], 1'b0};
                end
                if (step_reg == 4'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                step_reg <= step_reg + 4'd1;
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/extreme_value_row_selector.sv
`default_nettype none
// Channel  | Dir | Words                                   | Handshake
// s_axis   | in  | matrix elements and fetch requests      | tvalid/tready
// m_axis   | out | one selected-row word per fetch request | tvalid/tready
// apb      | in  | row/column/target counts, skip flag     | psel/penable
//
// One input word is taken at a time; s_axis_tready is high only when idle.
// Element: a seed write when seeding, else a scan of the column's kept slots and
// an update; a run start first runs the divider if a column is used, then clears
// the row map. A last element adds a map clear and marks each kept slot's rows
// per used column. Fetch: accept, scan 64-row map words, then output hand-off.
// Sync reset, then a row-map clear; a stalled m_axis holds the next fetch.
module extreme_value_row_selector (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // value[31:0], row[43:32], col[47:44]
    input  wire logic        s_axis_tuser,   // kind
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // row_index[11:0], final_one[12],
                                             // selected_count[25:13], zero
    output logic             m_axis_tuser,   // found
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import evrs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_DIV, S_CLR, S_ELEM, S_SCAN_RD, S_SCAN_CMP, S_UPD,
        S_FIN_RD, S_FIN_GET, S_MARK, S_MAP_RD, S_MAP_SET,
        S_FETCH_RD, S_FETCH_CHK, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [CNT_W-1:0]  row_count_reg, target_count_reg;
    logic [PCOL_W-1:0] column_count_reg;
    logic              skip_reg;

    logic [CNT_W-1:0]  n_rows, kc;
    logic [PCOL_W-1:0] p_cols, used_cols;

    assign n_rows    = (row_count_reg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count_reg;
    assign p_cols    = (column_count_reg > PCOL_W'(MAX_COLS)) ?
                       PCOL_W'(MAX_COLS) : column_count_reg;
    assign used_cols = (p_cols == '0) ? '0 : p_cols - PCOL_W'(skip_reg);
    assign kc        = (target_count_reg < n_rows) ? target_count_reg : n_rows;

    // APB
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_ROW_COUNT:    prdata = 32'(row_count_reg);
            REG_COLUMN_COUNT: prdata = 32'(column_count_reg);
            REG_TARGET_COUNT: prdata = 32'(target_count_reg);
            REG_SKIP_FIRST:   prdata = 32'(skip_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= '0;
            column_count_reg <= '0;
            target_count_reg <= '0;
            skip_reg         <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ROW_COUNT:    row_count_reg    <= pwdata[CNT_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[PCOL_W-1:0];
                REG_TARGET_COUNT: target_count_reg <= pwdata[CNT_W-1:0];
                REG_SKIP_FIRST:   skip_reg         <= pwdata[0];
                default:          skip_reg         <= skip_reg;
            endcase
        end
    end

    // latched word
    logic signed [VALUE_W-1:0] value_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [COL_W-1:0]          col_reg;
    logic                      last_reg;

    // run state
    logic [PS_W-1:0]   per_side_reg;
    logic [CNT_W-1:0]  cursor_reg, total_reg, fetched_reg;
    logic [MAP_AW-1:0] clr_idx_reg;
    logic              clr_fin_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [PCOL_W-1:0] fcol_reg;
    logic              side_reg;
    logic [ROW_W-1:0]  rhi_reg, rlo_reg, mrow_reg;
    entry_t            hbest_reg, lbest_reg;
    logic [SLOT_W-1:0] hslot_reg, lslot_reg;

    // pending result
    logic [ROW_W-1:0]  pend_row_reg;
    logic              pend_found_reg, pend_final_reg;

    // slot memories: per column, MAX_PER_SIDE entries each side
    entry_t hi_mem [1 << SLOT_AW];
    entry_t lo_mem [1 << SLOT_AW];
    entry_t hi_q, lo_q;
    logic [SLOT_AW-1:0] rd_addr, hi_waddr, lo_waddr;
    logic               hi_we, lo_we;
    entry_t             hi_wdata, lo_wdata;

    // row map: 64 rows per word
    logic [MAP_BITS-1:0] map_mem [MAP_DEPTH];
    logic [MAP_BITS-1:0] map_q, map_wdata;
    logic [MAP_AW-1:0]   map_raddr, map_waddr;
    logic                map_we;

    entry_t new_entry;
    assign new_entry = '{value: value_reg, row: row_reg};

    logic [ROW_W-1:0]    mark_row;
    logic [MAP_BITS-1:0] masked;
    assign mark_row = side_reg ? rlo_reg : rhi_reg;
    assign masked   = map_q & ({MAP_BITS{1'b1}} << cursor_reg[MAP_BIT_W-1:0]);

    always_comb begin
        rd_addr   = {fcol_reg[COL_W-1:0], slot_reg};
        hi_we     = 1'b0;
        lo_we     = 1'b0;
        hi_waddr  = {col_reg, row_reg[SLOT_W-1:0]};
        lo_waddr  = {col_reg, row_reg[SLOT_W-1:0]};
        hi_wdata  = new_entry;
        lo_wdata  = new_entry;
        map_raddr = cursor_reg[ROW_W-1:MAP_BIT_W];
        map_we    = 1'b0;
        map_waddr = clr_idx_reg;
        map_wdata = '0;
        case (state_reg)
            S_SCAN_RD: rd_addr = {col_reg, slot_reg};
            S_ELEM: begin
                if (!(col_reg >= p_cols[COL_W-1:0] && p_cols != PCOL_W'(MAX_COLS)) &&
                    !(col_reg == '0 && skip_reg) &&
                    CNT_W'(row_reg) < n_rows && PS_W'(row_reg) < per_side_reg &&
                    row_reg < ROW_W'(MAX_PER_SIDE)) begin
                    hi_we = 1'b1;
                    lo_we = 1'b1;
                end
            end
            S_UPD: begin
                hi_waddr = {col_reg, hslot_reg};
                lo_waddr = {col_reg, lslot_reg};
                hi_we    = value_reg > hbest_reg.value;
                lo_we    = value_reg < lbest_reg.value;
            end
            S_CLR, S_INIT: map_we = 1'b1;
            S_MAP_RD: map_raddr = mrow_reg[ROW_W-1:MAP_BIT_W];
            S_MAP_SET: begin
                map_waddr = mrow_reg[ROW_W-1:MAP_BIT_W];
                map_wdata = map_q | (MAP_BITS'(1) << mrow_reg[MAP_BIT_W-1:0]);
                map_we    = !map_q[mrow_reg[MAP_BIT_W-1:0]];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hi_we) hi_mem[hi_waddr] <= hi_wdata;
        if (lo_we) lo_mem[lo_waddr] <= lo_wdata;
        hi_q <= hi_mem[rd_addr];
        lo_q <= lo_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (map_we) map_mem[map_waddr] <= map_wdata;
        map_q <= map_mem[map_raddr];
    end

    // per-side divider
    logic             div_start, div_done;
    logic [CNT_W-1:0] div_q;
    logic             s_acc;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign div_start     = s_acc && s_axis_tuser == KIND_ELEMENT &&
                           s_axis_tdata[43:32] == '0 && s_axis_tdata[47:44] == '0 &&
                           used_cols != '0;

    evrs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (kc),
        .divisor  ({used_cols, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    logic elem_ignored, elem_seed;
    assign elem_ignored = (PCOL_W'(col_reg) >= p_cols) || (col_reg == '0 && skip_reg) ||
                          (CNT_W'(row_reg) >= n_rows);
    assign elem_seed    = PS_W'(row_reg) < per_side_reg && row_reg < ROW_W'(MAX_PER_SIDE);

    logic slot_last;
    assign slot_last = (PS_W'(slot_reg) == per_side_reg - PS_W'(1));

    // load the output register when it is free or being emptied
    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!m_axis_tvalid || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            per_side_reg  <= PS_W'(1);
            cursor_reg    <= '0;
            total_reg     <= '0;
            fetched_reg   <= '0;
            m_axis_tvalid <= 1'b0;
            clr_idx_reg   <= '0;
            clr_fin_reg   <= 1'b0;
        end else begin
            if (out_load) m_axis_tvalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        value_reg <= s_axis_tdata[31:0];
                        row_reg   <= s_axis_tdata[43:32];
                        col_reg   <= s_axis_tdata[47:44];
                        last_reg  <= s_axis_tlast;
                        if (s_axis_tuser == KIND_FETCH) begin
                            state_reg <= S_FETCH_RD;
                        end else if (s_axis_tdata[47:32] == '0) begin
                            // run start: reset counters, clear the map
                            cursor_reg  <= '0;
                            total_reg   <= '0;
                            fetched_reg <= '0;
                            clr_idx_reg <= '0;
                            clr_fin_reg <= 1'b0;
                            if (used_cols == '0) begin
                                per_side_reg <= PS_W'(1);
                                state_reg    <= S_CLR;
                            end else begin
                                state_reg <= S_DIV;
                            end
                        end else begin
                            state_reg <= S_ELEM;
                        end
                    end
                end
                S_INIT: begin
                    // clear the row map once after reset
                    clr_idx_reg <= clr_idx_reg + MAP_AW'(1);
                    if (clr_idx_reg == MAP_AW'(MAP_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (div_q == '0)
                            per_side_reg <= PS_W'(1);
                        else if (div_q > CNT_W'(MAX_PER_SIDE))
                            per_side_reg <= PS_W'(MAX_PER_SIDE);
                        else
                            per_side_reg <= div_q[PS_W-1:0];
                        state_reg <= S_CLR;
                    end
                end
                S_CLR: begin
                    clr_idx_reg <= clr_idx_reg + MAP_AW'(1);
                    if (clr_idx_reg == MAP_AW'(MAP_DEPTH - 1)) begin
                        if (!clr_fin_reg) begin
                            state_reg <= S_ELEM;
                        end else if (n_rows != '0 && used_cols != '0) begin
                            fcol_reg  <= PCOL_W'(skip_reg);
                            slot_reg  <= '0;
                            side_reg  <= 1'b0;
                            state_reg <= S_FIN_RD;
                        end else begin
                            cursor_reg  <= '0;
                            fetched_reg <= '0;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                S_ELEM: begin
                    if (elem_ignored || elem_seed) begin
                        if (last_reg) begin
                            total_reg   <= '0;
                            clr_idx_reg <= '0;
                            clr_fin_reg <= 1'b1;
                            state_reg   <= S_CLR;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        slot_reg  <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN_CMP;
                S_SCAN_CMP: begin
                    // weakest high: smallest value, lowest row on ties
                    if (slot_reg == '0 || hi_q.value < hbest_reg.value ||
                        (hi_q.value == hbest_reg.value && hi_q.row < hbest_reg.row)) begin
                        hbest_reg <= hi_q;
                        hslot_reg <= slot_reg;
                    end
                    // weakest low: largest value, highest row on ties
                    if (slot_reg == '0 || lo_q.value > lbest_reg.value ||
                        (lo_q.value == lbest_reg.value && lo_q.row > lbest_reg.row)) begin
                        lbest_reg <= lo_q;
                        lslot_reg <= slot_reg;
                    end
                    if (slot_last) begin
                        state_reg <= S_UPD;
                    end else begin
                        slot_reg  <= slot_reg + SLOT_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_UPD: begin
                    if (last_reg) begin
                        total_reg   <= '0;
                        clr_idx_reg <= '0;
                        clr_fin_reg <= 1'b1;
                        state_reg   <= S_CLR;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_FIN_RD: state_reg <= S_FIN_GET;
                S_FIN_GET: begin
                    rhi_reg   <= hi_q.row;
                    rlo_reg   <= lo_q.row;
                    side_reg  <= 1'b0;
                    state_reg <= S_MARK;
                end
                S_MARK, S_MAP_SET: begin
                    if (state_reg == S_MARK && CNT_W'(mark_row) < n_rows) begin
                        mrow_reg  <= mark_row;
                        state_reg <= S_MAP_RD;
                    end else begin
                        if (state_reg == S_MAP_SET && !map_q[mrow_reg[MAP_BIT_W-1:0]])
                            total_reg <= total_reg + CNT_W'(1);
                        if (!side_reg) begin
                            side_reg  <= 1'b1;
                            state_reg <= S_MARK;
                        end else if (!slot_last) begin
                            slot_reg  <= slot_reg + SLOT_W'(1);
                            state_reg <= S_FIN_RD;
                        end else if (fcol_reg + PCOL_W'(1) != p_cols) begin
                            slot_reg  <= '0;
                            fcol_reg  <= fcol_reg + PCOL_W'(1);
                            state_reg <= S_FIN_RD;
                        end else begin
                            cursor_reg  <= '0;
                            fetched_reg <= '0;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                S_MAP_RD: state_reg <= S_MAP_SET;
                S_FETCH_RD: begin
                    if (cursor_reg >= CNT_W'(MAX_ROWS)) begin
                        cursor_reg     <= CNT_W'(MAX_ROWS);
                        pend_row_reg   <= '0;
                        pend_found_reg <= 1'b0;
                        pend_final_reg <= 1'b0;
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_FETCH_CHK;
                    end
                end
                S_FETCH_CHK: begin
                    if (masked != '0) begin
                        pend_row_reg   <= {cursor_reg[ROW_W-1:MAP_BIT_W], lowest_set(masked)};
                        pend_found_reg <= 1'b1;
                        pend_final_reg <= (fetched_reg + CNT_W'(1) == total_reg);
                        fetched_reg    <= fetched_reg + CNT_W'(1);
                        cursor_reg     <= CNT_W'({cursor_reg[ROW_W-1:MAP_BIT_W],
                                                  lowest_set(masked)}) + CNT_W'(1);
                        state_reg      <= S_OUT;
                    end else begin
                        // advance to next map word
                        cursor_reg <= {cursor_reg[CNT_W-1:MAP_BIT_W] + (CNT_W-MAP_BIT_W)'(1),
                                       MAP_BIT_W'(0)};
                        state_reg  <= S_FETCH_RD;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_axis_tdata  <= {6'd0, total_reg, pend_final_reg, pend_row_reg};
                        m_axis_tuser  <= pend_found_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/evrs_checker.sv
`default_nettype none
module evrs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    import evrs_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word dropped or changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[12:0] == '0)
        else $error("miss word carries a row or final flag");

    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[25:13] != '0)
        else $error("hit word with zero selected count");
endmodule

bind extreme_value_row_selector evrs_checker u_evrs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: tb/sv/extreme_value_row_selector_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module extreme_value_row_selector_tb;
    import evrs_pkg::*;

    // one fetch result as the block should report it
    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic             found;
        logic             final_one;
        logic [CNT_W-1:0] count;
    } pick_t;

    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    extreme_value_row_selector DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state: register copies, kept extremes per column, row map.
    logic [CNT_W-1:0]          cfg_rows;
    logic [PCOL_W-1:0]         cfg_cols;
    logic [CNT_W-1:0]          cfg_target;
    logic                      cfg_skip;
    logic signed [VALUE_W-1:0] top_val [MAX_COLS][MAX_PER_SIDE];
    logic [ROW_W-1:0]          top_row [MAX_COLS][MAX_PER_SIDE];
    logic signed [VALUE_W-1:0] bot_val [MAX_COLS][MAX_PER_SIDE];
    logic [ROW_W-1:0]          bot_row [MAX_COLS][MAX_PER_SIDE];
    bit                        row_map [MAX_ROWS];
    int                        keep_n;
    int                        cursor;
    int                        map_total;

    pick_t pick_q[$];
    int    errors;
    int    words_sent;
    int    picks_checked;
    int    runs_done;
    int    stall_cycles;
    int    hold_cycles;
    bit    quiet;

    // Clock: 4 ns period.
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic int rows_in_use();
        return (cfg_rows < MAX_ROWS) ? int'(cfg_rows) : MAX_ROWS;
    endfunction

    function automatic int cols_in_use();
        return (cfg_cols < MAX_COLS) ? int'(cfg_cols) : MAX_COLS;
    endfunction

    function automatic int cols_scanned();
        if (cols_in_use() == 0) begin
            return 0;
        end
        return cols_in_use() - int'(cfg_skip);
    endfunction

    // Per-side depth that a run start would latch under the current registers.
    function automatic int side_depth();
        int used;
        int kc;
        int r;
        used = cols_scanned();
        kc   = (int'(cfg_target) < rows_in_use()) ? int'(cfg_target) : rows_in_use();
        r    = (used != 0) ? kc / (2 * used) : 1;
        if (r < 1) r = 1;
        if (r > MAX_PER_SIDE) r = MAX_PER_SIDE;
        return r;
    endfunction

    function automatic void track_element(logic signed [VALUE_W-1:0] v,
                                          int row, int col, bit is_last);
        int weak_top;
        int weak_bot;
        if (row == 0 && col == 0) begin
            keep_n = side_depth();
            foreach (row_map[i]) row_map[i] = 0;
            cursor    = 0;
            map_total = 0;
        end
        if (!(col >= cols_in_use() || (col == 0 && cfg_skip) || row >= rows_in_use())) begin
            if (row < keep_n) begin
                top_val[col][row] = v;
                top_row[col][row] = ROW_W'(row);
                bot_val[col][row] = v;
                bot_row[col][row] = ROW_W'(row);
            end else begin
                weak_top = 0;
                weak_bot = 0;
                for (int i = 1; i < keep_n; i++) begin
                    if (top_val[col][i] < top_val[col][weak_top] ||
                        (top_val[col][i] == top_val[col][weak_top] &&
                         top_row[col][i] < top_row[col][weak_top]))
                        weak_top = i;
                    if (bot_val[col][i] > bot_val[col][weak_bot] ||
                        (bot_val[col][i] == bot_val[col][weak_bot] &&
                         bot_row[col][i] > bot_row[col][weak_bot]))
                        weak_bot = i;
                end
                if (v > top_val[col][weak_top]) begin
                    top_val[col][weak_top] = v;
                    top_row[col][weak_top] = ROW_W'(row);
                end
                if (v < bot_val[col][weak_bot]) begin
                    bot_val[col][weak_bot] = v;
                    bot_row[col][weak_bot] = ROW_W'(row);
                end
            end
        end
        if (is_last) begin
            foreach (row_map[i]) row_map[i] = 0;
            if (rows_in_use() != 0 && cols_scanned() != 0) begin
                for (int c = int'(cfg_skip); c < cols_in_use(); c++) begin
                    for (int i = 0; i < keep_n; i++) begin
                        if (top_row[c][i] < rows_in_use()) row_map[top_row[c][i]] = 1;
                        if (bot_row[c][i] < rows_in_use()) row_map[bot_row[c][i]] = 1;
                    end
                end
            end
            map_total = 0;
            foreach (row_map[i]) map_total += row_map[i];
            cursor = 0;
        end
    endfunction

    function automatic pick_t next_pick();
        pick_t p;
        int    hit;
        p   = '0;
        hit = MAX_ROWS;
        for (int i = cursor; i < MAX_ROWS; i++) begin
            if (row_map[i]) begin
                hit = i;
                break;
            end
        end
        if (hit < MAX_ROWS) begin
            p.row_index = ROW_W'(hit);
            p.found     = 1'b1;
            p.final_one = 1'b1;
            for (int i = hit + 1; i < MAX_ROWS; i++) begin
                if (row_map[i]) begin
                    p.final_one = 1'b0;
                    break;
                end
            end
            cursor = hit + 1;
        end else begin
            cursor = MAX_ROWS;
        end
        p.count = CNT_W'(map_total);
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d (result %0d)",
                 what, got, want, picks_checked);
        errors++;
    endtask

    // Offer one word, at times after a random gap unless quiet; track it once accepted.
    task automatic send_word(logic kind, logic signed [VALUE_W-1:0] v,
                             int row, int col, bit is_last);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_axis_tdata  = {COL_W'(col), ROW_W'(row), v};
        s_axis_tuser  = kind;
        s_axis_tlast  = is_last;
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
        if (kind == KIND_FETCH) pick_q.insert(pick_q.size(), next_pick());
        else track_element(v, row, col, is_last);
    endtask

    task automatic send_fetch();
        send_word(KIND_FETCH, $urandom, $urandom_range(0, 4095),
                  $urandom_range(0, 15), $urandom_range(0, 1));
    endtask

    task automatic drain_picks();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pick_q.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Wait out any row-map rebuild still in flight, then program all registers.
    task automatic set_config(int rows, int cols, int target, bit skip);
        drain_picks();
        repeat (64 + 8 * keep_n * (cols_scanned() + 1) + 64) @(posedge aclk);
        apb_write(REG_ROW_COUNT, rows);
        apb_write(REG_COLUMN_COUNT, cols);
        apb_write(REG_TARGET_COUNT, target);
        apb_write(REG_SKIP_FIRST, 32'(skip));
        cfg_rows   = CNT_W'(rows);
        cfg_cols   = PCOL_W'(cols);
        cfg_target = CNT_W'(target);
        cfg_skip   = skip;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 6) - 3;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // Send one matrix in row-major order. Noise words are fetches or
    // elements the block ignores; they never start or end a run.
    task automatic send_matrix(int rows_sent, int mode, bit noisy, bit broken);
        int  ncol;
        int  stop;
        bit  tail;
        ncol = cols_in_use();
        if (ncol == 0 || rows_sent == 0) begin
            send_word(KIND_ELEMENT, pick_value(mode), 0, 0, 1'b1);
            runs_done++;
            return;
        end
        stop = broken ? (rows_sent + 1) / 2 : rows_sent;
        for (int r = 0; r < stop; r++) begin
            for (int c = 0; c < ncol; c++) begin
                tail = !broken && r == stop - 1 && c == ncol - 1;
                send_word(KIND_ELEMENT, pick_value(mode), r, c, tail);
                if (noisy && !tail && $urandom_range(0, 7) == 0) begin
                    if ($urandom_range(0, 2) == 0) send_fetch();
                    else if (ncol < MAX_COLS)
                        send_word(KIND_ELEMENT, $urandom, $urandom_range(1, 4095),
                                  $urandom_range(ncol, 15), 1'b0);
                    else if (rows_in_use() < MAX_ROWS)
                        send_word(KIND_ELEMENT, $urandom,
                                  $urandom_range(rows_in_use(), 4095),
                                  $urandom_range(0, 15), 1'b0);
                end
            end
        end
        if (!broken) runs_done++;
    endtask

    task automatic fetch_all(int extra);
        int n;
        n = map_total - cursor + extra;
        if (n < 1) n = 1;
        repeat (n) send_fetch();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        send_fetch();
        drain_picks();
    endtask

    task automatic test_directed();
        // ties: equal values never displace a kept entry
        set_config(8, 2, 8, 1'b0);
        send_matrix(8, 1, 1'b0, 1'b0);
        fetch_all(1);
        // value extremes with the intercept column skipped
        set_config(6, 3, 6, 1'b1);
        send_matrix(6, 2, 1'b0, 1'b0);
        fetch_all(1);
        // only column skipped, no rows, no columns: empty selections
        set_config(4, 1, 4, 1'b1);
        send_matrix(4, 0, 1'b0, 1'b0);
        send_fetch();
        set_config(0, 2, 5, 1'b0);
        send_matrix(0, 0, 1'b0, 1'b0);
        send_fetch();
        set_config(3, 0, 3, 1'b0);
        send_matrix(0, 0, 1'b0, 1'b0);
        send_fetch();
        drain_picks();
    endtask

    task automatic test_register_limits();
        // clamped row and column counts, sixteen columns, zero target
        set_config(8191, 31, 0, 1'b0);
        send_matrix(2, 0, 1'b0, 1'b0);
        send_word(KIND_ELEMENT, $urandom, 4095, 15, 1'b0);
        fetch_all(0);
        // deepest per-side store on a single column, largest target
        set_config(4096, 1, 8191, 1'b0);
        send_matrix(70, 0, 1'b0, 1'b0);
        fetch_all(1);
        drain_picks();
    endtask

    task automatic test_backpressure();
        set_config(12, 2, 12, 1'b0);
        send_matrix(12, 0, 1'b0, 1'b0);
        drain_picks();
        // hold the result side off while fetches keep coming
        hold_cycles = 400;
        repeat (8) send_fetch();
        drain_picks();
        fetch_all(1);
        drain_picks();
    endtask

    task automatic test_random_runs(int goal);
        int  rows;
        int  cols;
        int  target;
        bit  skip;
        int  depth;
        int  sent;
        while (words_sent < goal) begin
            case ($urandom_range(0, 19))
                0:       rows = 0;
                1:       rows = $urandom_range(25, 8191);
                default: rows = $urandom_range(1, 20);
            endcase
            case ($urandom_range(0, 19))
                0:       cols = $urandom_range(16, 31);
                1:       cols = 0;
                default: cols = $urandom_range(1, 5);
            endcase
            target = (rows > 24 || cols > 5) ? $urandom_range(0, 40) :
                     ($urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
                                                : $urandom_range(0, 2 * rows));
            skip = $urandom_range(0, 1);
            set_config(rows, cols, target, skip);
            depth = side_depth();
            sent  = (rows_in_use() <= 20) ? rows_in_use() : $urandom_range(depth, 20);
            if (cols_in_use() > 5 && sent > 3) sent = (depth > 3) ? depth : 3;
            send_matrix(sent, $urandom_range(0, 2), 1'b1, $urandom_range(0, 7) == 0);
            fetch_all($urandom_range(0, 2) - 1);
            if ($urandom_range(0, 5) == 0) drain_picks();
        end
        drain_picks();
    endtask

    // ---------------------------------------------------------------- main

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_ELEMENT;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_rows      = '0;
        cfg_cols      = '0;
        cfg_target    = '0;
        cfg_skip      = 1'b0;
        keep_n        = 1;
        cursor        = 0;
        map_total     = 0;
        foreach (row_map[i]) row_map[i] = 0;
        errors        = 0;
        words_sent    = 0;
        picks_checked = 0;
        runs_done     = 0;
        hold_cycles   = 0;
        quiet         = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_directed();
        test_register_limits();
        test_backpressure();
        test_random_runs(words_sent + 70);
        quiet = 1'b1;
        test_random_runs(words_sent + 30);

        drain_picks();
        repeat (200) @(posedge aclk);
        $display("covered %0d words in %0d complete runs, %0d fetch results checked",
                 words_sent, runs_done, picks_checked);
        $display("register extremes, ties, value extremes, skipped and empty selections");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result side: random stalls in bursts, long hold-offs on request.
    initial begin
        int burst;
        burst         = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                hold_cycles--;
            end else if (quiet) begin
                m_axis_tready = 1'b1;
            end else if (burst > 0) begin
                burst--;
            end else begin
                m_axis_tready = ($urandom_range(0, 2) != 0);
                burst         = $urandom_range(1, 19);
            end
        end
    end

    // Check each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        pick_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pick_q.size() == 0) begin
                report_mismatch("unexpected word, row_index", m_axis_tdata[11:0], -1);
            end else begin
                want = pick_q.pop_front();
                if (m_axis_tdata[11:0] != want.row_index)
                    report_mismatch("row_index", m_axis_tdata[11:0], want.row_index);
                if (m_axis_tuser != want.found)
                    report_mismatch("found", m_axis_tuser, want.found);
                if (m_axis_tdata[12] != want.final_one)
                    report_mismatch("final_one", m_axis_tdata[12], want.final_one);
                if (m_axis_tdata[25:13] != want.count)
                    report_mismatch("selected_count", m_axis_tdata[25:13], want.count);
            end
            picks_checked++;
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial stall_cycles = 0;

endmodule
`default_nettype wire

FILE: filelist.f
src/evrs_pkg.sv
src/evrs_div.sv
src/extreme_value_row_selector.sv
src/evrs_checker.sv
tb/sv/extreme_value_row_selector_tb.sv
